### rtl/core/pfxev_pkg.sv
// Package: shared constants, types and decode helpers of the prefix expression evaluator.
package pfxev_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned STEP_W      = $clog2(DATA_W);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OVER  = 2'd1;
  localparam logic [1:0] ERR_UNDER = 2'd2;
  localparam logic [1:0] ERR_DIV0  = 2'd3;

  localparam logic [DATA_W-1:0] EMPTY_POP_VALUE = DATA_W'(CH_SPACE);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } pfxev_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_X,
    ST_POP_Y,
    ST_TAKE_Y,
    ST_EXEC,
    ST_PUSH,
    ST_POP_FIN,
    ST_EMIT
  } pfxev_state_e;

  typedef struct packed {
    logic      start;
    pfxev_op_e op;
  } pfxev_alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } pfxev_alu_rsp_t;

  function automatic logic is_arith(logic [7:0] ch);
    return ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  endfunction

  function automatic logic is_paren(logic [7:0] ch);
    return ch inside {CH_LPAR, CH_RPAR};
  endfunction

  function automatic pfxev_op_e op_of(logic [7:0] ch);
    pfxev_op_e op;
    case (ch)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      default:  op = OP_DIV;
    endcase
    return op;
  endfunction

  function automatic logic [1:0] flag_err(logic [1:0] cur, logic [1:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

### rtl/core/pfxev_if.sv
// Interfaces: valid/ready channels for characters in and results out.
interface pfxev_in_if;
  import pfxev_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface pfxev_out_if;
  import pfxev_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [1:0]               status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

### rtl/core/pfxev_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfxev_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pfxev_alu.sv
// Iterative arithmetic unit: one shared adder for add, sub, shift-add multiply, restoring divide.
module pfxev_alu
  import pfxev_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfxev_alu_req_t      req_i,
  input  logic [DATA_W-1:0]   x_i,
  input  logic [DATA_W-1:0]   y_i,
  output pfxev_alu_rsp_t      rsp_o,
  output logic [DATA_W-1:0]   res_o
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  logic              busy_q, busy_d;
  pfxev_op_e         op_q, op_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic              div0_q, div0_d;
  logic [DATA_W-1:0] res_q, res_d;

  logic [DATA_W:0]   add_a, add_b, sum;
  logic              add_sub;
  logic [DATA_W-1:0] abs_x, abs_y;

  assign abs_x = x_i[DATA_W-1] ? (~x_i + DATA_W'(1)) : x_i;
  assign abs_y = y_i[DATA_W-1] ? (~y_i + DATA_W'(1)) : y_i;

  always_comb begin
    add_a   = {1'b0, x_i};
    add_b   = {1'b0, y_i};
    add_sub = 1'b0;
    if (busy_q) begin
      if (op_q == OP_MUL) begin
        add_a = {1'b0, acc_q};
        add_b = {1'b0, a_q};
      end else begin
        add_a   = {acc_q, b_q[DATA_W-1]};
        add_b   = {1'b0, a_q};
        add_sub = 1'b1;
      end
    end else if (req_i.op == OP_SUB) begin
      add_sub = 1'b1;
    end
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + (DATA_W + 1)'(add_sub);

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    div0_d = 1'b0;
    res_d  = res_q;
    if (busy_q) begin
      if (op_q == OP_MUL) begin
        if (b_q[0]) begin
          acc_d = sum[DATA_W-1:0];
        end
        a_d = {a_q[DATA_W-2:0], 1'b0};
        b_d = {1'b0, b_q[DATA_W-1:1]};
      end else if (!sum[DATA_W]) begin
        acc_d = sum[DATA_W-1:0];
        b_d   = {b_q[DATA_W-2:0], 1'b1};
      end else begin
        acc_d = {acc_q[DATA_W-2:0], b_q[DATA_W-1]};
        b_d   = {b_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == OP_MUL) begin
          res_d = acc_d;
        end else begin
          res_d = neg_q ? (~b_d + DATA_W'(1)) : b_d;
        end
      end
    end else if (req_i.start) begin
      op_d  = req_i.op;
      cnt_d = '0;
      acc_d = '0;
      case (req_i.op)
        OP_ADD, OP_SUB: begin
          res_d  = sum[DATA_W-1:0];
          done_d = 1'b1;
        end
        OP_MUL: begin
          a_d    = x_i;
          b_d    = y_i;
          busy_d = 1'b1;
        end
        default: begin
          if (y_i == '0) begin
            res_d  = '0;
            done_d = 1'b1;
            div0_d = 1'b1;
          end else begin
            a_d    = abs_y;
            b_d    = abs_x;
            neg_d  = x_i[DATA_W-1] ^ y_i[DATA_W-1];
            busy_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div0_q <= 1'b0;
      op_q   <= OP_ADD;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div0_q <= div0_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.div0 = div0_q;
  assign res_o      = res_q;

endmodule

### rtl/core/prefix_expression_evaluator.sv
// Top level: prefix expression evaluator with a RAM stack and an iterative arithmetic unit.
//
// Usage: characters of a prefix expression enter on in_i (ch, last), last character
// first; last = 1 marks the first character of the string and closes the expression.
// An operand character pushes its code minus 48; + - * / pop two values and push the
// answer; a parenthesis pops two values. On the closing character one result leaves
// on out_o: the final popped value and a sticky status (0 ok, 1 overflow,
// 2 underflow, 3 divide by zero).
// Per character: + and - take one pass through the adder; * and / run a 32-step
// shift-add or restoring-divide loop through the one shared adder; a zero divisor skips it.
// A closing character adds the final pop and the load of the result register.
// Stack reads go through the registered read port of the stack RAM.
// in_i.ready is high only while the sequencer is idle; one character is in work at
// a time.
// The result register holds its transaction until out_o.ready; a new character is
// still accepted meanwhile, and only the next closing character waits for it.
// Reset empties the stack, clears the status and the valid flag of the result register;
// the result value and status and the stack RAM itself are not cleared.
module prefix_expression_evaluator
  import pfxev_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pfxev_in_if.sink    in_i,
  pfxev_out_if.source out_o
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  pfxev_state_e      state_q, state_d;
  logic [7:0]        ch_q, ch_d;
  logic              last_q, last_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] push_q, push_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic [1:0]        out_status_q, out_status_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  cnt_dec;
  logic [DATA_W-1:0] pop_val;
  logic              emit_fire;

  pfxev_alu_req_t    alu_req;
  pfxev_alu_rsp_t    alu_rsp;
  logic [DATA_W-1:0] alu_res;

  pfxev_ram #(
    .Width (DATA_W),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfxev_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .x_i    (x_q),
    .y_i    (pop_val),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign pop_val   = hit_q ? ram_rdata : EMPTY_POP_VALUE;
  assign ram_raddr = cnt_dec[ADDR_W-1:0];
  assign ram_waddr = cnt_q[ADDR_W-1:0];
  assign ram_wdata = push_q;
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    ch_d         = ch_q;
    last_d       = last_q;
    x_d          = x_q;
    hit_d        = hit_q;
    push_d       = push_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    alu_req      = '{start: 1'b0, op: op_of(ch_q)};
    in_i.ready   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ch_d   = in_i.ch;
          last_d = in_i.last;
          if (is_arith(in_i.ch) || is_paren(in_i.ch)) begin
            state_d = ST_POP_X;
          end else begin
            push_d  = DATA_W'(in_i.ch) - DATA_W'(CH_ZERO);
            state_d = ST_PUSH;
          end
        end
      end
      ST_POP_X, ST_POP_Y, ST_POP_FIN: begin
        if (state_q == ST_POP_Y) begin
          x_d = pop_val;
        end
        if (cnt_q == '0) begin
          hit_d = 1'b0;
          err_d = flag_err(err_q, ERR_UNDER);
        end else begin
          hit_d  = 1'b1;
          ram_re = 1'b1;
          cnt_d  = cnt_dec;
        end
        case (state_q)
          ST_POP_X: state_d = ST_POP_Y;
          ST_POP_Y: state_d = ST_TAKE_Y;
          default:  state_d = ST_EMIT;
        endcase
      end
      ST_TAKE_Y: begin
        if (is_paren(ch_q)) begin
          state_d = last_q ? ST_POP_FIN : ST_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (alu_rsp.done) begin
          push_d = alu_res;
          if (alu_rsp.div0) begin
            err_d = flag_err(err_q, ERR_DIV0);
          end
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (cnt_q == CNT_FULL) begin
          err_d = flag_err(err_q, ERR_OVER);
        end else begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        state_d = last_q ? ST_POP_FIN : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d  = 1'b1;
          out_value_d  = pop_val;
          out_status_d = err_q;
          cnt_d        = '0;
          err_d        = ERR_NONE;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
      ch_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      last_q      <= last_d;
      ch_q        <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    push_q       <= push_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("stack count above depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (cnt_q == '0) && (err_q == ERR_NONE) && out_valid_q)
    else $error("expression end did not clear stack and status");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) && !emit_fire |=> err_q == $past(err_q))
    else $error("status changed before expression end");

  a_alu_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == ST_EXEC)
    else $error("arithmetic result outside execute state");

endmodule
